### sv/afm_pkg.sv
package afm_pkg;

   // table geometry
   localparam int NUM_SYMBOLS = 256;
   localparam int IDX_W       = $clog2(NUM_SYMBOLS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int DATA_W      = 16;

   localparam logic [DATA_W-1:0] LIMIT_RESET = 16'd16384;

   // action codes; the unused code behaves as a query
   typedef logic [1:0] action_type;
   localparam action_type ACT_ADD   = 2'd0;
   localparam action_type ACT_SET   = 2'd1;
   localparam action_type ACT_QUERY = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_TOT_SUB,
      S_TOT_ADD,
      S_CNT_WR,
      S_CHECK,
      S_WALK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_ACC
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic              halve;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              carry;
      logic [DATA_W-1:0] term;
   } alu_res_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } tbl_wr_type;

endpackage

### sv/adaptive_frequency_model_core.sv
// Sequence: a query on symbol s goes through CHECK, then WALK over entries 0..s, then DONE to the
//   output register; an add first passes TOT_ADD and CNT_WR, a set TOT_SUB, TOT_ADD and CNT_WR;
//   an update that rescales walks the whole table. One word at a time: not ready until its result is loaded.
// Walk rate: one table entry a cycle through the shared adder.
// Reset: synchronous, active high. After reset a clearing pass zeroes all NUM_SYMBOLS (256) entries,
//   one entry a cycle, before the first input word is taken.
module adaptive_frequency_model_core (
   input  logic        clock,
   input  logic        reset,
   // input word: [1:0] action, [9:2] symbol, [25:10] value, [31:26] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result word: [15:0] count, [31:16] cum_low, [47:32] cum_high, [63:48] total
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // rescale limit register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int IDX_W  = afm_pkg::IDX_W;
   localparam int CNT_W  = afm_pkg::CNT_W;
   localparam int DATA_W = afm_pkg::DATA_W;

   // input field split
   logic [1:0]  req_action;
   logic [7:0]  req_symbol;
   logic [15:0] req_value;
   assign req_action = req_tdata[1:0];
   assign req_symbol = req_tdata[9:2];
   assign req_value  = req_tdata[25:10];

   afm_pkg::state_type state_ff, state_in;

   // item registers
   afm_pkg::action_type act_ff, act_in;
   logic [IDX_W-1:0]    sym_ff, sym_in;
   logic                sym_ok_ff, sym_ok_in;
   logic                upd_ff, upd_in;
   logic [DATA_W-1:0]   val_ff, val_in;

   // model state
   logic [DATA_W-1:0]   tot_ff, tot_in;
   logic [DATA_W-1:0]   limit_ff, limit_in;

   // table walk
   logic                halve_ff, halve_in;
   logic [IDX_W-1:0]    last_ff, last_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                dv_ff, dv_in;
   logic [IDX_W-1:0]    tag_ff, tag_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic [DATA_W-1:0]   low_ff, low_in;
   logic [DATA_W-1:0]   count_ff, count_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                slot_free;
   logic                issuing;
   logic                walk_end;
   logic                req_sym_ok;

   afm_pkg::tbl_wr_type  tbl_wr;
   logic [IDX_W-1:0]     tbl_rd_addr;
   logic [DATA_W-1:0]    tbl_rd_data;
   afm_pkg::alu_cmd_type alu_cmd;
   afm_pkg::alu_res_type alu_res;

   afm_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   afm_alu u_alu (
      .cmd (alu_cmd),
      .res (alu_res)
   );

   assign req_tready = (state_ff == afm_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_sym_ok = (32'(req_symbol) < afm_pkg::NUM_SYMBOLS);
   assign issuing    = (rd_idx_ff <= {1'b0, last_ff});
   assign walk_end   = dv_ff && (tag_ff == last_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         afm_pkg::S_CLEAR: begin
            if (rd_idx_ff[IDX_W-1:0] == IDX_W'(afm_pkg::NUM_SYMBOLS - 1)) begin
               state_in = afm_pkg::S_IDLE;
            end
         end
         afm_pkg::S_IDLE: begin
            if (accept) begin
               if (req_sym_ok && req_action == afm_pkg::ACT_ADD) begin
                  state_in = afm_pkg::S_TOT_ADD;
               end else if (req_sym_ok && req_action == afm_pkg::ACT_SET) begin
                  state_in = afm_pkg::S_TOT_SUB;
               end else begin
                  state_in = afm_pkg::S_CHECK;
               end
            end
         end
         afm_pkg::S_TOT_SUB: state_in = afm_pkg::S_TOT_ADD;
         afm_pkg::S_TOT_ADD: state_in = afm_pkg::S_CNT_WR;
         afm_pkg::S_CNT_WR:  state_in = afm_pkg::S_CHECK;
         afm_pkg::S_CHECK:   state_in = afm_pkg::S_WALK;
         afm_pkg::S_WALK: begin
            if (walk_end) begin
               state_in = afm_pkg::S_DONE;
            end
         end
         afm_pkg::S_DONE: begin
            if (slot_free) begin
               state_in = afm_pkg::S_IDLE;
            end
         end
         default: state_in = afm_pkg::S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      act_in       = act_ff;
      sym_in       = sym_ff;
      sym_ok_in    = sym_ok_ff;
      upd_in       = upd_ff;
      val_in       = val_ff;
      tot_in       = tot_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      halve_in     = halve_ff;
      last_in      = last_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = 1'b0;
      tag_in       = tag_ff;
      acc_in       = acc_ff;
      low_in       = low_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      tbl_wr      = '0;
      tbl_rd_addr = sym_ff;

      alu_cmd.op    = afm_pkg::ALU_ADD;
      alu_cmd.halve = 1'b0;
      alu_cmd.a     = tot_ff;
      alu_cmd.b     = val_ff;

      case (state_ff)
         afm_pkg::S_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = rd_idx_ff[IDX_W-1:0];
            tbl_wr.data = '0;
            rd_idx_in   = rd_idx_ff + CNT_W'(1);
         end
         afm_pkg::S_IDLE: begin
            // read the symbol's count up front so it is ready next cycle
            tbl_rd_addr = IDX_W'(req_symbol);
            if (accept) begin
               act_in    = req_action;
               sym_in    = IDX_W'(req_symbol);
               sym_ok_in = req_sym_ok;
               upd_in    = req_sym_ok && (req_action == afm_pkg::ACT_ADD
                                          || req_action == afm_pkg::ACT_SET);
               val_in    = req_value;
            end
         end
         afm_pkg::S_TOT_SUB: begin
            alu_cmd.op = afm_pkg::ALU_SUB;
            alu_cmd.b  = tbl_rd_data;
            tot_in     = alu_res.sum;
         end
         afm_pkg::S_TOT_ADD: begin
            tot_in = alu_res.sum;
         end
         afm_pkg::S_CNT_WR: begin
            alu_cmd.a   = tbl_rd_data;
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = sym_ff;
            tbl_wr.data = (act_ff == afm_pkg::ACT_ADD) ? alu_res.sum : val_ff;
         end
         afm_pkg::S_CHECK: begin
            // total >= limit via borrow of total - limit
            alu_cmd.op = afm_pkg::ALU_SUB;
            alu_cmd.b  = limit_ff;
            halve_in   = upd_ff && alu_res.carry;
            last_in    = (halve_in || !sym_ok_ff) ? IDX_W'(afm_pkg::NUM_SYMBOLS - 1) : sym_ff;
            rd_idx_in  = '0;
            acc_in     = '0;
            low_in     = '0;
            count_in   = '0;
         end
         afm_pkg::S_WALK: begin
            tbl_rd_addr = rd_idx_ff[IDX_W-1:0];
            if (issuing) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            dv_in  = issuing;
            tag_in = rd_idx_ff[IDX_W-1:0];
            if (dv_ff) begin
               alu_cmd.op    = afm_pkg::ALU_ACC;
               alu_cmd.halve = halve_ff;
               alu_cmd.a     = acc_ff;
               alu_cmd.b     = tbl_rd_data;
               acc_in        = alu_res.sum;
               if (halve_ff) begin
                  tbl_wr.en   = 1'b1;
                  tbl_wr.addr = tag_ff;
                  tbl_wr.data = alu_res.term;
               end
               if (sym_ok_ff && tag_ff == sym_ff) begin
                  low_in   = acc_ff;
                  count_in = alu_res.term;
               end
               if (tag_ff == last_ff) begin
                  if (halve_ff) begin
                     tot_in = alu_res.sum;
                  end
                  if (!sym_ok_ff) begin
                     low_in = alu_res.sum;
                  end
               end
            end
         end
         afm_pkg::S_DONE: begin
            alu_cmd.a = low_ff;
            alu_cmd.b = count_ff;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tot_ff, alu_res.sum, low_ff, count_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afm_pkg::S_CLEAR;
         rd_idx_ff    <= '0;
         dv_ff        <= 1'b0;
         tot_ff       <= '0;
         limit_ff     <= afm_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         dv_ff        <= dv_in;
         tot_ff       <= tot_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      sym_ff      <= sym_in;
      sym_ok_ff   <= sym_ok_in;
      upd_ff      <= upd_in;
      val_ff      <= val_in;
      halve_ff    <= halve_in;
      last_ff     <= last_in;
      tag_ff      <= tag_in;
      acc_ff      <= acc_in;
      low_ff      <= low_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("ready before the table clearing pass");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == afm_pkg::S_WALK |-> rd_idx_ff <= CNT_W'(afm_pkg::NUM_SYMBOLS))
      else $error("table walk ran past the end");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == afm_pkg::S_DONE && rsp_valid_ff && !rsp_tready
      |=> state_ff == afm_pkg::S_DONE)
      else $error("result left done while the output register was full");
`endif

endmodule

### sv/afm_table.sv
// count table: one write port, one registered read port
module afm_table (
   input  logic                       clock,
   input  afm_pkg::tbl_wr_type        wr,
   input  logic [afm_pkg::IDX_W-1:0]  rd_addr,
   output logic [afm_pkg::DATA_W-1:0] rd_data
);

   logic [afm_pkg::DATA_W-1:0] table_mem [afm_pkg::NUM_SYMBOLS];
   logic [afm_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/afm_alu.sv
// shared 16-bit adder; SUB carry-out means a >= b
module afm_alu (
   input  afm_pkg::alu_cmd_type cmd,
   output afm_pkg::alu_res_type res
);

   logic [afm_pkg::DATA_W:0]   half_full;
   logic [afm_pkg::DATA_W-1:0] term;
   logic [afm_pkg::DATA_W-1:0] opb;
   logic                       cin;
   logic [afm_pkg::DATA_W:0]   full;

   always_comb begin
      // (c + 1) / 2, rounding up
      half_full = ({1'b0, cmd.b} + 17'd1) >> 1;
      term      = cmd.halve ? half_full[afm_pkg::DATA_W-1:0] : cmd.b;
      case (cmd.op)
         afm_pkg::ALU_ADD: begin
            opb = cmd.b;
            cin = 1'b0;
         end
         afm_pkg::ALU_SUB: begin
            opb = ~cmd.b;
            cin = 1'b1;
         end
         afm_pkg::ALU_ACC: begin
            opb = term;
            cin = 1'b0;
         end
         default: begin
            opb = cmd.b;
            cin = 1'b0;
         end
      endcase
      full      = {1'b0, cmd.a} + {1'b0, opb} + {{afm_pkg::DATA_W{1'b0}}, cin};
      res.sum   = full[afm_pkg::DATA_W-1:0];
      res.carry = full[afm_pkg::DATA_W];
      res.term  = term;
   end

endmodule
